### rtl/core/pnmhp_pkg.sv
// Shared types and constants for the PNM header parser.
package pnmhp_pkg;

    // Default widths of the decoded dimensions and of the byte offset.
    localparam int DIMENSION_BITS_DEF = 16;
    localparam int OFFSET_BITS_DEF    = 32;

    // Character codes used by the header syntax.
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SIX   = 8'h36;

    // Maxval limits and the thresholds that set the sample width.
    localparam logic [30:0] MAXVAL_LIMIT = 31'h7FFF_FFFF;
    localparam logic [30:0] BITS8_MAX    = 31'h0000_00FF;
    localparam logic [30:0] BITS16_MAX   = 31'h0000_FFFF;
    localparam logic [30:0] BITS24_MAX   = 31'h00FF_FFFF;

    // Type digit codes; the bad-signature mark shares the type register.
    localparam logic [2:0] TYPE_NONE      = 3'd0;
    localparam logic [2:0] TYPE_PBM_ASCII = 3'd1;
    localparam logic [2:0] TYPE_PPM_ASCII = 3'd3;
    localparam logic [2:0] TYPE_PBM_RAW   = 3'd4;
    localparam logic [2:0] TYPE_PPM_RAW   = 3'd6;
    localparam logic [2:0] TYPE_BAD_P     = 3'd7;

    localparam logic [1:0] COMPS_GREY   = 2'd1;
    localparam logic [1:0] COMPS_COLOUR = 2'd3;

    localparam logic [5:0] SBITS_1  = 6'd1;
    localparam logic [5:0] SBITS_8  = 6'd8;
    localparam logic [5:0] SBITS_16 = 6'd16;
    localparam logic [5:0] SBITS_24 = 6'd24;
    localparam logic [5:0] SBITS_32 = 6'd32;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_BAD_SIGNATURE = 3'd1,
        ST_BAD_TYPE      = 3'd2,
        ST_MAXVAL_ZERO   = 3'd3,
        ST_MAXVAL_BIG    = 3'd4,
        ST_TRUNCATED     = 3'd5,
        ST_DIM_OVERFLOW  = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        PH_SIG_P     = 4'd0,
        PH_SIG_DIGIT = 4'd1,
        PH_SIG_EOL   = 4'd2,
        PH_SKIP_W    = 4'd3,
        PH_NUM_W     = 4'd4,
        PH_SKIP_H    = 4'd5,
        PH_NUM_H     = 4'd6,
        PH_SKIP_M    = 4'd7,
        PH_NUM_M     = 4'd8,
        PH_WAIT      = 4'd9
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } byte_beat_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  image_type;
        logic [1:0]  component_count;
        logic [5:0]  sample_bits;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [30:0] max_sample;
        logic [31:0] data_offset;
    } header_beat_t;

endpackage

### rtl/core/pnmhp_parser.sv
// Per-byte header parsing state and the result decode for one byte.
module pnmhp_parser #(
    parameter int DIMENSION_BITS = pnmhp_pkg::DIMENSION_BITS_DEF,
    parameter int OFFSET_BITS    = pnmhp_pkg::OFFSET_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  pnmhp_pkg::byte_beat_t   beat,
    output logic                    hit,
    output pnmhp_pkg::header_beat_t result
);

    localparam logic [30:0] DIM_MAX = 31'((64'd1 << DIMENSION_BITS) - 64'd1);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    pnmhp_pkg::phase_t           phase_reg, phase_next;
    logic [OFFSET_BITS-1:0]      pos_reg, pos_next;
    logic [2:0]                  type_reg, type_next;
    logic                        cmt_reg, cmt_next;
    logic [DIMENSION_BITS-1:0]   wid_reg, wid_next;
    logic [DIMENSION_BITS-1:0]   hgt_reg, hgt_next;
    logic [30:0]                 acc_reg, acc_next;
    logic                        ovf_reg, ovf_next;

    // Decoded effect of the current byte, before emission and end of file.
    pnmhp_pkg::phase_t           ph_adv;
    logic [2:0]                  type_adv;
    logic                        cmt_adv;
    logic [DIMENSION_BITS-1:0]   wid_adv;
    logic [DIMENSION_BITS-1:0]   hgt_adv;
    logic [30:0]                 acc_adv;
    logic                        ovf_adv;

    logic                        hit_raw;
    pnmhp_pkg::status_t          st_raw;
    logic [2:0]                  rtype;
    logic [1:0]                  rcomps;
    logic [5:0]                  rbits;
    logic [DIMENSION_BITS-1:0]   rw;
    logic [DIMENSION_BITS-1:0]   rh;
    logic [30:0]                 rmax;
    logic                        roff;

    logic [7:0]                  b;
    logic                        is_eol, is_ws, is_hash, is_dig, is_other;
    logic                        in_w, in_h, in_m, bitmap, colour;
    logic [30:0]                 limit;
    logic [30:0]                 acc_src;
    logic                        ovf_src;
    logic [34:0]                 mac;
    logic                        mac_ovf;
    logic [30:0]                 mac_val;
    logic                        fin;
    logic [30:0]                 fv;
    logic                        fo;
    logic [OFFSET_BITS:0]        off_sum;
    logic [OFFSET_BITS-1:0]      off;
    logic [31:0]                 rw32, rh32;

    function automatic logic [5:0] sample_width(input logic [30:0] mv);
        logic [5:0] r;
        if (mv <= pnmhp_pkg::BITS8_MAX) r = pnmhp_pkg::SBITS_8;
        else if (mv <= pnmhp_pkg::BITS16_MAX) r = pnmhp_pkg::SBITS_16;
        else if (mv <= pnmhp_pkg::BITS24_MAX) r = pnmhp_pkg::SBITS_24;
        else r = pnmhp_pkg::SBITS_32;
        return r;
    endfunction

    // Byte classes, number selection and the multiply-by-ten accumulate.
    always_comb
    begin
        b        = beat.data_byte;
        is_eol   = (b == pnmhp_pkg::CH_LF) || (b == pnmhp_pkg::CH_CR);
        is_ws    = is_eol || (b == pnmhp_pkg::CH_SPACE) || (b == pnmhp_pkg::CH_TAB);
        is_hash  = (b == pnmhp_pkg::CH_HASH);
        is_dig   = b inside {[pnmhp_pkg::CH_ZERO:pnmhp_pkg::CH_NINE]};
        is_other = !is_ws && !is_hash && !is_dig;

        in_w = phase_reg inside {pnmhp_pkg::PH_SKIP_W, pnmhp_pkg::PH_NUM_W};
        in_h = phase_reg inside {pnmhp_pkg::PH_SKIP_H, pnmhp_pkg::PH_NUM_H};
        in_m = phase_reg inside {pnmhp_pkg::PH_SKIP_M, pnmhp_pkg::PH_NUM_M};
        bitmap = type_reg inside {pnmhp_pkg::TYPE_PBM_ASCII, pnmhp_pkg::TYPE_PBM_RAW};
        colour = type_reg inside {pnmhp_pkg::TYPE_PPM_ASCII, pnmhp_pkg::TYPE_PPM_RAW};

        limit = in_m ? pnmhp_pkg::MAXVAL_LIMIT : DIM_MAX;

        // A digit seen while skipping starts a fresh number.
        if (phase_reg inside {pnmhp_pkg::PH_NUM_W, pnmhp_pkg::PH_NUM_H, pnmhp_pkg::PH_NUM_M})
        begin
            acc_src = acc_reg;
            ovf_src = ovf_reg;
        end
        else
        begin
            acc_src = '0;
            ovf_src = 1'b0;
        end

        // The low nibble of an ASCII digit is its value.
        mac     = 35'({acc_src, 3'b000}) + 35'({acc_src, 1'b0}) + 35'(b[3:0]);
        mac_ovf = ovf_src || (mac > 35'(limit));
        mac_val = mac_ovf ? limit : mac[30:0];

        off_sum = {1'b0, pos_reg} + (OFFSET_BITS + 1)'(is_ws);
        off     = off_sum[OFFSET_BITS] ? OFF_MAX : off_sum[OFFSET_BITS-1:0];
    end

    // What the byte does to the parse, including a number that ends on it and
    // every number after it that a stray character ends with the value zero.
    always_comb
    begin
        ph_adv   = phase_reg;
        type_adv = type_reg;
        cmt_adv  = cmt_reg;
        wid_adv  = wid_reg;
        hgt_adv  = hgt_reg;
        acc_adv  = acc_reg;
        ovf_adv  = ovf_reg;
        hit_raw  = 1'b0;
        st_raw   = pnmhp_pkg::ST_OK;
        rtype    = type_reg;
        rcomps   = '0;
        rbits    = '0;
        rw       = '0;
        rh       = '0;
        rmax     = '0;
        roff     = 1'b0;
        fin      = 1'b0;
        fv       = '0;
        fo       = 1'b0;

        case (phase_reg)
            pnmhp_pkg::PH_SIG_P:
            begin
                type_adv = (b == pnmhp_pkg::CH_P) ? pnmhp_pkg::TYPE_NONE : pnmhp_pkg::TYPE_BAD_P;
                ph_adv   = pnmhp_pkg::PH_SIG_DIGIT;
            end
            pnmhp_pkg::PH_SIG_DIGIT:
            begin
                if (type_reg != pnmhp_pkg::TYPE_BAD_P)
                begin
                    type_adv = (b inside {[pnmhp_pkg::CH_ONE:pnmhp_pkg::CH_SIX]}) ?
                               b[2:0] : pnmhp_pkg::TYPE_NONE;
                end
                ph_adv = pnmhp_pkg::PH_SIG_EOL;
            end
            pnmhp_pkg::PH_SIG_EOL:
            begin
                rtype = pnmhp_pkg::TYPE_NONE;
                if ((type_reg == pnmhp_pkg::TYPE_BAD_P) || !is_eol)
                begin
                    hit_raw = 1'b1;
                    st_raw  = pnmhp_pkg::ST_BAD_SIGNATURE;
                end
                else if (type_reg == pnmhp_pkg::TYPE_NONE)
                begin
                    hit_raw = 1'b1;
                    st_raw  = pnmhp_pkg::ST_BAD_TYPE;
                end
                else
                begin
                    ph_adv  = pnmhp_pkg::PH_SKIP_W;
                    cmt_adv = 1'b0;
                end
            end
            pnmhp_pkg::PH_SKIP_W, pnmhp_pkg::PH_SKIP_H, pnmhp_pkg::PH_SKIP_M:
            begin
                if (cmt_reg)
                begin
                    if (is_eol)
                        cmt_adv = 1'b0;
                end
                else if (is_hash)
                begin
                    cmt_adv = 1'b1;
                end
                else if (is_dig)
                begin
                    ph_adv  = in_w ? pnmhp_pkg::PH_NUM_W :
                              in_h ? pnmhp_pkg::PH_NUM_H : pnmhp_pkg::PH_NUM_M;
                    acc_adv = mac_val;
                    ovf_adv = mac_ovf;
                end
                else if (is_other)
                begin
                    fin = 1'b1;
                end
            end
            pnmhp_pkg::PH_NUM_W, pnmhp_pkg::PH_NUM_H, pnmhp_pkg::PH_NUM_M:
            begin
                if (is_dig)
                begin
                    acc_adv = mac_val;
                    ovf_adv = mac_ovf;
                end
                else
                begin
                    fin = 1'b1;
                    fv  = acc_reg;
                    fo  = ovf_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (fin)
        begin
            if (in_m)
            begin
                hit_raw = 1'b1;
                rw      = wid_reg;
                rh      = hgt_reg;
                rmax    = fv;
                roff    = 1'b1;
                if (fo)
                    st_raw = pnmhp_pkg::ST_MAXVAL_BIG;
                else if (fv == '0)
                    st_raw = pnmhp_pkg::ST_MAXVAL_ZERO;
                else
                begin
                    st_raw = pnmhp_pkg::ST_OK;
                    rcomps = colour ? pnmhp_pkg::COMPS_COLOUR : pnmhp_pkg::COMPS_GREY;
                    rbits  = sample_width(fv);
                end
            end
            else if (fo)
            begin
                hit_raw = 1'b1;
                st_raw  = pnmhp_pkg::ST_DIM_OVERFLOW;
            end
            else
            begin
                if (in_w)
                begin
                    wid_adv = fv[DIMENSION_BITS-1:0];
                    hgt_adv = '0;
                    rw      = fv[DIMENSION_BITS-1:0];
                    rh      = '0;
                end
                else
                begin
                    hgt_adv = fv[DIMENSION_BITS-1:0];
                    rw      = wid_reg;
                    rh      = fv[DIMENSION_BITS-1:0];
                end
                // A stray character ends the height too; a bitmap is complete
                // once the height ends, otherwise the maxval ends at zero.
                if (bitmap && (in_h || is_other))
                begin
                    hit_raw = 1'b1;
                    st_raw  = pnmhp_pkg::ST_OK;
                    rcomps  = pnmhp_pkg::COMPS_GREY;
                    rbits   = pnmhp_pkg::SBITS_1;
                    rmax    = 31'd1;
                    roff    = 1'b1;
                end
                else if (is_other)
                begin
                    hit_raw = 1'b1;
                    st_raw  = pnmhp_pkg::ST_MAXVAL_ZERO;
                    roff    = 1'b1;
                end
                else
                begin
                    ph_adv  = in_w ? pnmhp_pkg::PH_SKIP_H : pnmhp_pkg::PH_SKIP_M;
                    cmt_adv = is_hash;
                end
            end
        end
    end

    // Next state: a result parks the parse until end of file, which clears it.
    always_comb
    begin
        if (beat.end_of_file)
        begin
            phase_next = pnmhp_pkg::PH_SIG_P;
            pos_next   = '0;
            type_next  = pnmhp_pkg::TYPE_NONE;
            cmt_next   = 1'b0;
            wid_next   = '0;
            hgt_next   = '0;
            acc_next   = '0;
            ovf_next   = 1'b0;
        end
        else
        begin
            phase_next = hit_raw ? pnmhp_pkg::PH_WAIT : ph_adv;
            pos_next   = (pos_reg == OFF_MAX) ? pos_reg : pos_reg + 1'b1;
            type_next  = type_adv;
            cmt_next   = cmt_adv;
            wid_next   = wid_adv;
            hgt_next   = hgt_adv;
            acc_next   = acc_adv;
            ovf_next   = ovf_adv;
        end
    end

    // Result: a decoded header or, at an early end of file, a truncation.
    always_comb
    begin
        rw32 = 32'(rw);
        rh32 = 32'(rh);
        hit  = hit_raw || (beat.end_of_file && (ph_adv != pnmhp_pkg::PH_WAIT));
        if (hit_raw)
        begin
            result.status          = st_raw;
            result.image_type      = rtype;
            result.component_count = rcomps;
            result.sample_bits     = rbits;
            result.image_width     = rw32[15:0];
            result.image_height    = rh32[15:0];
            result.max_sample      = rmax;
            result.data_offset     = roff ? 32'(off) : '0;
        end
        else
        begin
            result.status          = pnmhp_pkg::ST_TRUNCATED;
            result.image_type      = (ph_adv inside {[pnmhp_pkg::PH_SKIP_W:pnmhp_pkg::PH_NUM_M]}) ?
                                     type_adv : pnmhp_pkg::TYPE_NONE;
            result.component_count = '0;
            result.sample_bits     = '0;
            result.image_width     = '0;
            result.image_height    = '0;
            result.max_sample      = '0;
            result.data_offset     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pnmhp_pkg::PH_SIG_P;
            pos_reg   <= '0;
            type_reg  <= pnmhp_pkg::TYPE_NONE;
            cmt_reg   <= 1'b0;
            wid_reg   <= '0;
            hgt_reg   <= '0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            type_reg  <= type_next;
            cmt_reg   <= cmt_next;
            wid_reg   <= wid_next;
            hgt_reg   <= hgt_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

### rtl/core/pnm_header_parser_top.sv
// Top level of the PNM header parser: input stage, parser and result register.
// A byte accepted into the input register is parsed from there, and its result, if any,
// is written to the result register when the result slot is free.
// Throughput: one byte per cycle, unless a byte that produces a result waits for a full result register.
// Reset (rst_n, asynchronous, active low) empties both stages and restarts the
// parse at the first signature byte of a new file with the byte count at zero.
module pnm_header_parser_top #(
    parameter int DIMENSION_BITS = pnmhp_pkg::DIMENSION_BITS_DEF,
    parameter int OFFSET_BITS    = pnmhp_pkg::OFFSET_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // Byte stream of the file.
    input  logic                    byte_valid,
    output logic                    byte_ready,
    input  pnmhp_pkg::byte_beat_t   byte_data,
    // Decoded header, at most one beat per file.
    output logic                    hdr_valid,
    input  logic                    hdr_ready,
    output pnmhp_pkg::header_beat_t hdr_data
);

    // Input stage: holds one byte beat in front of the parser.
    logic                    in_valid_reg, in_valid_next;
    pnmhp_pkg::byte_beat_t   in_data_reg;

    // Result stage: holds one header beat until the consumer takes it.
    logic                    out_valid_reg, out_valid_next;
    pnmhp_pkg::header_beat_t out_data_reg;

    logic                    parse_hit;
    pnmhp_pkg::header_beat_t parse_result;
    logic                    parse_go;
    logic                    in_take;

    // The parser consumes the held byte unless that byte produces a result
    // while the result register still holds one that has not been taken.
    // Bytes that produce nothing flow on even while the output is stalled.
    assign parse_go   = in_valid_reg &&
                        (!parse_hit || !out_valid_reg || hdr_ready);
    assign byte_ready = !in_valid_reg || parse_go;
    assign in_take    = byte_valid && byte_ready;

    assign hdr_valid  = out_valid_reg;
    assign hdr_data   = out_data_reg;

    pnmhp_parser #(
        .DIMENSION_BITS (DIMENSION_BITS),
        .OFFSET_BITS    (OFFSET_BITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (parse_go),
        .beat   (in_data_reg),
        .hit    (parse_hit),
        .result (parse_result)
    );

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (parse_go)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (parse_go && parse_hit)
            out_valid_next = 1'b1;
        else if (hdr_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= byte_data;
        if (parse_go && parse_hit)
            out_data_reg <= parse_result;
    end

`ifndef SYNTHESIS
    // A new result never overwrites one that the consumer has not yet taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (parse_go && parse_hit) |-> (!out_valid_reg || hdr_ready))
        else $error("header result overwritten before it was taken");

    // Back pressure on the byte side only comes from a full input stage.
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> in_valid_reg)
        else $error("byte stream stalled with an empty input stage");

    // A successful header always reports its component count and sample width.
    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (parse_go && parse_hit && (parse_result.status == pnmhp_pkg::ST_OK)) |=>
        ((out_data_reg.component_count != 2'd0) && (out_data_reg.sample_bits != 6'd0)))
        else $error("good header without component count or sample width");
`endif

endmodule
